// ===== hw/rtl/cau_pkg.sv =====
// shared types, constants and helper functions of the complex arithmetic unit
package cau_pkg;

   localparam int DATA_W       = 32;
   localparam int FRAC_W       = 16;
   localparam int TOL_W        = 16;
   localparam int CMD_W        = 4;
   localparam int STAT_W       = 2;
   localparam int WIDE_W       = 2 * DATA_W;
   localparam int CORDIC_STEPS = 20;
   localparam int CORDIC_W     = DATA_W + 3;
   localparam int ANG_W        = 26;
   localparam int GAIN_W       = 30;
   localparam int DIV_STEPS    = DATA_W;
   localparam int CORDIC_LAT   = CORDIC_STEPS + 3;
   localparam int DIV_LAT      = DIV_STEPS + 2;

   localparam logic [TOL_W-1:0]        TOL_RESET = 16'd7;
   localparam logic [GAIN_W-1:0]       INV_GAIN  = 30'd652032874;
   localparam logic signed [ANG_W-1:0] DEG180    = 26'sd11796480;

   localparam logic [WIDE_W-1:0] MAX_NEG_MAG = WIDE_W'(1) << (DATA_W - 1);
   localparam logic [WIDE_W-1:0] MAX_POS     = MAX_NEG_MAG - WIDE_W'(1);

   localparam logic [CMD_W-1:0] CMD_ADD   = 4'd0;
   localparam logic [CMD_W-1:0] CMD_SUB   = 4'd1;
   localparam logic [CMD_W-1:0] CMD_MUL   = 4'd2;
   localparam logic [CMD_W-1:0] CMD_DIV   = 4'd3;
   localparam logic [CMD_W-1:0] CMD_CONJ  = 4'd4;
   localparam logic [CMD_W-1:0] CMD_EQ    = 4'd5;
   localparam logic [CMD_W-1:0] CMD_NE    = 4'd6;
   localparam logic [CMD_W-1:0] CMD_MAG   = 4'd7;
   localparam logic [CMD_W-1:0] CMD_ANGLE = 4'd8;

   localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
   localparam logic [STAT_W-1:0] ST_DIV0 = 2'd1;
   localparam logic [STAT_W-1:0] ST_OVF  = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]         command;
      logic signed [DATA_W-1:0] a_re;
      logic signed [DATA_W-1:0] a_im;
      logic signed [DATA_W-1:0] b_re;
      logic signed [DATA_W-1:0] b_im;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] res_re;
      logic signed [DATA_W-1:0] res_im;
      logic                     compare_true;
      logic [STAT_W-1:0]        status;
   } rsp_type;

   // result on its way down the pipe
   typedef struct packed {
      logic signed [DATA_W-1:0] re;
      logic signed [DATA_W-1:0] im;
      logic                     cmp;
      logic                     ovf;
      logic                     div0;
   } res_type;

   typedef struct packed {
      logic                     ovf;
      logic signed [DATA_W-1:0] val;
   } sat_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] re;
      logic signed [DATA_W-1:0] im;
      logic                     ovf;
      logic                     div0;
   } div_out_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] mag;
      logic                     mag_ovf;
      logic signed [DATA_W-1:0] angle;
   } cordic_out_type;

   // arctangent of 2^-i in degrees, q16.16
   function automatic logic signed [ANG_W-1:0] atan_deg(input int step);
      logic signed [ANG_W-1:0] r;
      case (step)
         0:       r = 26'sd2949120;
         1:       r = 26'sd1740967;
         2:       r = 26'sd919879;
         3:       r = 26'sd466945;
         4:       r = 26'sd234379;
         5:       r = 26'sd117304;
         6:       r = 26'sd58666;
         7:       r = 26'sd29335;
         8:       r = 26'sd14668;
         9:       r = 26'sd7334;
         10:      r = 26'sd3667;
         11:      r = 26'sd1833;
         12:      r = 26'sd917;
         13:      r = 26'sd458;
         14:      r = 26'sd229;
         15:      r = 26'sd115;
         16:      r = 26'sd57;
         17:      r = 26'sd29;
         18:      r = 26'sd14;
         19:      r = 26'sd7;
         default: r = '0;
      endcase
      return r;
   endfunction

   // sign and magnitude to saturated signed value
   function automatic sat_type sat_sm(input logic neg, input logic [WIDE_W-1:0] mag);
      sat_type r;
      r.ovf = 1'b0;
      if (neg) begin
         if (mag > MAX_NEG_MAG) begin
            r.ovf = 1'b1;
            r.val = signed'(DATA_W'(MAX_NEG_MAG));
         end else begin
            r.val = signed'(DATA_W'('0 - mag));
         end
      end else begin
         if (mag > MAX_POS) begin
            r.ovf = 1'b1;
            r.val = signed'(DATA_W'(MAX_POS));
         end else begin
            r.val = signed'(DATA_W'(mag));
         end
      end
      return r;
   endfunction

   // saturate a value one bit wider than the data path
   function automatic sat_type sat_s33(input logic signed [DATA_W:0] v);
      logic [DATA_W:0] m;
      m = v[DATA_W] ? (~v + (DATA_W+1)'(1)) : v;
      return sat_sm(v[DATA_W], WIDE_W'(m));
   endfunction

endpackage

// ===== hw/rtl/cau_divider.sv =====
// pipelined restoring divider for the complex quotient, both parts share the denominator
module cau_divider (
   input  logic                             clock,
   input  logic                             enable,
   input  logic signed [cau_pkg::WIDE_W:0]  num_re,
   input  logic signed [cau_pkg::WIDE_W:0]  num_im,
   input  logic [cau_pkg::WIDE_W-1:0]       den,
   output cau_pkg::div_out_type             div_out
);

   typedef struct packed {
      logic [cau_pkg::WIDE_W-1:0] rem_re;
      logic [cau_pkg::WIDE_W-1:0] rem_im;
      logic [cau_pkg::DATA_W-1:0] q_re;
      logic [cau_pkg::DATA_W-1:0] q_im;
      logic [cau_pkg::WIDE_W-1:0] den;
      logic                       neg_re;
      logic                       neg_im;
      logic                       big_re;
      logic                       big_im;
      logic                       zero;
   } stage_type;

   stage_type            st_ff [0:cau_pkg::DIV_STEPS];
   stage_type            st_in [0:cau_pkg::DIV_STEPS];
   cau_pkg::div_out_type out_ff;
   cau_pkg::div_out_type out_in;

   // one quotient bit: shift in the next dividend bit, subtract when it fits
   function automatic logic [cau_pkg::WIDE_W+cau_pkg::DATA_W-1:0] div_step(
      input logic [cau_pkg::WIDE_W-1:0] rem,
      input logic [cau_pkg::DATA_W-1:0] q,
      input logic [cau_pkg::WIDE_W-1:0] d
   );
      logic [cau_pkg::WIDE_W-1:0] t;
      logic                       b;
      t = {rem[cau_pkg::WIDE_W-2:0], q[cau_pkg::DATA_W-1]};
      b = (t >= d);
      if (b) begin
         t = t - d;
      end
      return {t, q[cau_pkg::DATA_W-2:0], b};
   endfunction

   function automatic logic [cau_pkg::WIDE_W-1:0] abs_w(input logic signed [cau_pkg::WIDE_W:0] v);
      return cau_pkg::WIDE_W'(v[cau_pkg::WIDE_W] ? -v : v);
   endfunction

   function automatic logic is_big(input logic [cau_pkg::WIDE_W-1:0] m,
                                   input logic [cau_pkg::WIDE_W-1:0] d);
      return {{cau_pkg::FRAC_W{1'b0}}, m} >= {d, {cau_pkg::FRAC_W{1'b0}}};
   endfunction

   function automatic cau_pkg::sat_type finish(input logic neg, input logic big,
                                               input logic [cau_pkg::DATA_W-1:0] q);
      cau_pkg::sat_type r;
      if (big) begin
         r = cau_pkg::sat_sm(neg, cau_pkg::MAX_NEG_MAG + cau_pkg::WIDE_W'(1));
      end else begin
         r = cau_pkg::sat_sm(neg, cau_pkg::WIDE_W'(q));
      end
      return r;
   endfunction

   always_comb begin
      logic [cau_pkg::WIDE_W-1:0] mr;
      logic [cau_pkg::WIDE_W-1:0] mi;
      cau_pkg::sat_type           sr;
      cau_pkg::sat_type           si;
      mr = abs_w(num_re);
      mi = abs_w(num_im);
      // quotient fits in data width unless big, so the top bits start as remainder
      st_in[0].rem_re = mr >> cau_pkg::FRAC_W;
      st_in[0].rem_im = mi >> cau_pkg::FRAC_W;
      st_in[0].q_re   = {mr[cau_pkg::FRAC_W-1:0], {(cau_pkg::DATA_W-cau_pkg::FRAC_W){1'b0}}};
      st_in[0].q_im   = {mi[cau_pkg::FRAC_W-1:0], {(cau_pkg::DATA_W-cau_pkg::FRAC_W){1'b0}}};
      st_in[0].den    = den;
      st_in[0].neg_re = num_re[cau_pkg::WIDE_W];
      st_in[0].neg_im = num_im[cau_pkg::WIDE_W];
      st_in[0].big_re = is_big(mr, den);
      st_in[0].big_im = is_big(mi, den);
      st_in[0].zero   = (den == '0);
      for (int k = 1; k <= cau_pkg::DIV_STEPS; k++) begin
         st_in[k] = st_ff[k-1];
         {st_in[k].rem_re, st_in[k].q_re} = div_step(st_ff[k-1].rem_re, st_ff[k-1].q_re,
                                                     st_ff[k-1].den);
         {st_in[k].rem_im, st_in[k].q_im} = div_step(st_ff[k-1].rem_im, st_ff[k-1].q_im,
                                                     st_ff[k-1].den);
      end
      sr = finish(st_ff[cau_pkg::DIV_STEPS].neg_re, st_ff[cau_pkg::DIV_STEPS].big_re,
                  st_ff[cau_pkg::DIV_STEPS].q_re);
      si = finish(st_ff[cau_pkg::DIV_STEPS].neg_im, st_ff[cau_pkg::DIV_STEPS].big_im,
                  st_ff[cau_pkg::DIV_STEPS].q_im);
      if (st_ff[cau_pkg::DIV_STEPS].zero) begin
         out_in.re   = '0;
         out_in.im   = '0;
         out_in.ovf  = 1'b0;
         out_in.div0 = 1'b1;
      end else begin
         out_in.re   = sr.val;
         out_in.im   = si.val;
         out_in.ovf  = sr.ovf | si.ovf;
         out_in.div0 = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k <= cau_pkg::DIV_STEPS; k++) begin
            st_ff[k] <= st_in[k];
         end
         out_ff <= out_in;
      end
   end

   assign div_out = out_ff;

endmodule

// ===== hw/rtl/cau_cordic.sv =====
// pipelined vectoring cordic giving magnitude and angle in degrees
module cau_cordic (
   input  logic                              clock,
   input  logic                              enable,
   input  logic signed [cau_pkg::DATA_W-1:0] x_in,
   input  logic signed [cau_pkg::DATA_W-1:0] y_in,
   output cau_pkg::cordic_out_type           cordic_out
);

   localparam int N    = cau_pkg::CORDIC_STEPS;
   localparam int XW   = cau_pkg::CORDIC_W;
   localparam int PW   = XW - 1 + cau_pkg::GAIN_W;

   logic signed [XW-1:0]             x_ff [0:N];
   logic signed [XW-1:0]             y_ff [0:N];
   logic signed [cau_pkg::ANG_W-1:0] z_ff [0:N];
   logic                             zero_ff [0:N];
   logic signed [XW-1:0]             x_in_s [0:N];
   logic signed [XW-1:0]             y_in_s [0:N];
   logic signed [cau_pkg::ANG_W-1:0] z_in_s [0:N];
   logic                             zero_in_s [0:N];
   logic [PW-1:0]                    prod_ff;
   logic [PW-1:0]                    prod_in;
   logic signed [cau_pkg::DATA_W-1:0] ang_ff;
   logic signed [cau_pkg::DATA_W-1:0] ang_in;
   cau_pkg::cordic_out_type          out_ff;
   cau_pkg::cordic_out_type          out_in;

   always_comb begin
      logic signed [XW-1:0]             x0;
      logic signed [XW-1:0]             y0;
      logic signed [XW-1:0]             dx;
      logic signed [XW-1:0]             dy;
      logic signed [cau_pkg::ANG_W-1:0] zc;
      cau_pkg::sat_type                 ms;
      x0 = XW'(x_in);
      y0 = XW'(y_in);
      // left half plane: rotate by 180 first
      if (x_in < 0) begin
         x_in_s[0] = -x0;
         y_in_s[0] = -y0;
         z_in_s[0] = (y_in >= 0) ? cau_pkg::DEG180 : -cau_pkg::DEG180;
      end else begin
         x_in_s[0] = x0;
         y_in_s[0] = y0;
         z_in_s[0] = '0;
      end
      zero_in_s[0] = (x_in == 0) && (y_in == 0);
      for (int i = 0; i < N; i++) begin
         dx = y_ff[i] >>> i;
         dy = x_ff[i] >>> i;
         zero_in_s[i+1] = zero_ff[i];
         if (y_ff[i] > 0) begin
            x_in_s[i+1] = x_ff[i] + dx;
            y_in_s[i+1] = y_ff[i] - dy;
            z_in_s[i+1] = z_ff[i] + cau_pkg::atan_deg(i);
         end else begin
            x_in_s[i+1] = x_ff[i] - dx;
            y_in_s[i+1] = y_ff[i] + dy;
            z_in_s[i+1] = z_ff[i] - cau_pkg::atan_deg(i);
         end
      end
      zc = z_ff[N];
      if (zc > cau_pkg::DEG180) begin
         zc = cau_pkg::DEG180;
      end
      if (zc < -cau_pkg::DEG180) begin
         zc = -cau_pkg::DEG180;
      end
      if (zero_ff[N]) begin
         zc = '0;
      end
      ang_in  = cau_pkg::DATA_W'(zc);
      // x is never negative here
      prod_in = PW'(x_ff[N][XW-2:0]) * PW'(cau_pkg::INV_GAIN);
      ms = cau_pkg::sat_sm(1'b0, cau_pkg::WIDE_W'(prod_ff >> cau_pkg::GAIN_W));
      out_in.mag     = ms.val;
      out_in.mag_ovf = ms.ovf;
      out_in.angle   = ang_ff;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k <= N; k++) begin
            x_ff[k]    <= x_in_s[k];
            y_ff[k]    <= y_in_s[k];
            z_ff[k]    <= z_in_s[k];
            zero_ff[k] <= zero_in_s[k];
         end
         prod_ff <= prod_in;
         ang_ff  <= ang_in;
         out_ff  <= out_in;
      end
   end

   assign cordic_out = out_ff;

endmodule

// ===== hw/rtl/complex_arithmetic_unit_core.sv =====
// top level of the complex arithmetic unit: front stages, result pipe and output register
//
// channel | dir | handshake           | word
// req_    | in  | req_valid/req_stall | command, a_re, a_im, b_re, b_im
// rsp_    | out | rsp_valid/rsp_stall | res_re, res_im, compare_true, status
// csr_    | in  | csr_valid/csr_ready | equal_tolerance
//
// one word enters per cycle while req_stall is low; every command travels the same
// result pipe from the accepting edge to the edge that loads the output register,
// its length set by the divider pipe. the whole pipe advances
// unless the output register holds a word that is stalled, so a stall freezes
// everything and nothing is lost or repeated. synchronous reset clears the
// valid bits and sets the tolerance to TOL_RESET
module complex_arithmetic_unit_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  cau_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output cau_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [cau_pkg::TOL_W-1:0] csr_data
);

   // stage numbers of the result pipe
   localparam int S_EARLY = 2;
   localparam int S_MUL   = S_EARLY + 2;
   localparam int S_CORD  = 1 + cau_pkg::CORDIC_LAT;
   localparam int S_LAST  = 3 + cau_pkg::DIV_LAT;

   typedef struct packed {
      logic                      valid;
      logic [cau_pkg::CMD_W-1:0] cmd;
      cau_pkg::res_type          res;
   } pipe_type;

   typedef struct packed {
      logic signed [cau_pkg::WIDE_W-1:0] arbr;
      logic signed [cau_pkg::WIDE_W-1:0] aibi;
      logic signed [cau_pkg::WIDE_W-1:0] aibr;
      logic signed [cau_pkg::WIDE_W-1:0] arbi;
      logic signed [cau_pkg::WIDE_W-1:0] brbr;
      logic signed [cau_pkg::WIDE_W-1:0] bibi;
   } prod_type;

   typedef struct packed {
      logic signed [cau_pkg::WIDE_W:0] mul_re;
      logic signed [cau_pkg::WIDE_W:0] mul_im;
      logic signed [cau_pkg::WIDE_W:0] div_re;
      logic signed [cau_pkg::WIDE_W:0] div_im;
      logic [cau_pkg::WIDE_W-1:0]      den;
   } sum_type;

   logic                      adv;
   logic [cau_pkg::TOL_W-1:0] tol_ff;
   logic                      v1_ff;
   cau_pkg::req_type          item_ff;
   prod_type                  prod_ff;
   prod_type                  prod_in;
   sum_type                   sum_ff;
   sum_type                   sum_in;
   cau_pkg::res_type          early_res;
   cau_pkg::res_type          mul_res;
   pipe_type                  pipe_ff [S_EARLY:S_LAST];
   pipe_type                  pipe_in [S_EARLY:S_LAST];
   cau_pkg::cordic_out_type   cord;
   cau_pkg::div_out_type      dv;
   logic                      rsp_valid_ff;
   cau_pkg::rsp_type          rsp_data_ff;
   cau_pkg::rsp_type          rsp_in;

   // pipe moves unless a finished word is held at the output
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // simple commands straight from the input word
   always_comb begin
      logic signed [cau_pkg::DATA_W:0] s_re;
      logic signed [cau_pkg::DATA_W:0] s_im;
      logic [cau_pkg::DATA_W:0]        d_re;
      logic [cau_pkg::DATA_W:0]        d_im;
      logic [cau_pkg::DATA_W:0]        tol_x;
      logic                            eq;
      cau_pkg::sat_type                sr;
      cau_pkg::sat_type                si;
      early_res = '0;
      s_re  = (cau_pkg::DATA_W+1)'(item_ff.a_re) - (cau_pkg::DATA_W+1)'(item_ff.b_re);
      s_im  = (cau_pkg::DATA_W+1)'(item_ff.a_im) - (cau_pkg::DATA_W+1)'(item_ff.b_im);
      d_re  = s_re[cau_pkg::DATA_W] ? (~s_re + (cau_pkg::DATA_W+1)'(1)) : s_re;
      d_im  = s_im[cau_pkg::DATA_W] ? (~s_im + (cau_pkg::DATA_W+1)'(1)) : s_im;
      tol_x = (cau_pkg::DATA_W+1)'(tol_ff);
      eq    = (d_re < tol_x) && (d_im < tol_x);
      sr    = '0;
      si    = '0;
      case (item_ff.command)
         cau_pkg::CMD_ADD: begin
            sr = cau_pkg::sat_s33((cau_pkg::DATA_W+1)'(item_ff.a_re)
                                  + (cau_pkg::DATA_W+1)'(item_ff.b_re));
            si = cau_pkg::sat_s33((cau_pkg::DATA_W+1)'(item_ff.a_im)
                                  + (cau_pkg::DATA_W+1)'(item_ff.b_im));
         end
         cau_pkg::CMD_SUB: begin
            sr = cau_pkg::sat_s33(s_re);
            si = cau_pkg::sat_s33(s_im);
         end
         cau_pkg::CMD_CONJ: begin
            sr = cau_pkg::sat_s33((cau_pkg::DATA_W+1)'(item_ff.a_re));
            si = cau_pkg::sat_s33(-(cau_pkg::DATA_W+1)'(item_ff.a_im));
         end
         cau_pkg::CMD_EQ: begin
            early_res.cmp = eq;
         end
         cau_pkg::CMD_NE: begin
            early_res.cmp = !eq;
         end
         default: begin
            early_res.cmp = 1'b0;
         end
      endcase
      early_res.re  = sr.val;
      early_res.im  = si.val;
      early_res.ovf = sr.ovf | si.ovf;
   end

   // partial products, then their sums
   always_comb begin
      prod_in.arbr = item_ff.a_re * item_ff.b_re;
      prod_in.aibi = item_ff.a_im * item_ff.b_im;
      prod_in.aibr = item_ff.a_im * item_ff.b_re;
      prod_in.arbi = item_ff.a_re * item_ff.b_im;
      prod_in.brbr = item_ff.b_re * item_ff.b_re;
      prod_in.bibi = item_ff.b_im * item_ff.b_im;
      sum_in.mul_re = (cau_pkg::WIDE_W+1)'(prod_ff.arbr) - (cau_pkg::WIDE_W+1)'(prod_ff.aibi);
      sum_in.mul_im = (cau_pkg::WIDE_W+1)'(prod_ff.aibr) + (cau_pkg::WIDE_W+1)'(prod_ff.arbi);
      sum_in.div_re = (cau_pkg::WIDE_W+1)'(prod_ff.arbr) + (cau_pkg::WIDE_W+1)'(prod_ff.aibi);
      sum_in.div_im = (cau_pkg::WIDE_W+1)'(prod_ff.aibr) - (cau_pkg::WIDE_W+1)'(prod_ff.arbi);
      sum_in.den    = prod_ff.brbr + prod_ff.bibi;
   end

   // product truncated toward zero and saturated
   always_comb begin
      logic                       nr;
      logic                       ni;
      logic [cau_pkg::WIDE_W-1:0] mr;
      logic [cau_pkg::WIDE_W-1:0] mi;
      cau_pkg::sat_type           sr;
      cau_pkg::sat_type           si;
      nr = sum_ff.mul_re[cau_pkg::WIDE_W];
      ni = sum_ff.mul_im[cau_pkg::WIDE_W];
      mr = cau_pkg::WIDE_W'(nr ? -sum_ff.mul_re : sum_ff.mul_re);
      mi = cau_pkg::WIDE_W'(ni ? -sum_ff.mul_im : sum_ff.mul_im);
      sr = cau_pkg::sat_sm(nr, mr >> cau_pkg::FRAC_W);
      si = cau_pkg::sat_sm(ni, mi >> cau_pkg::FRAC_W);
      mul_res      = '0;
      mul_res.re   = sr.val;
      mul_res.im   = si.val;
      mul_res.ovf  = sr.ovf | si.ovf;
   end

   cau_cordic u_cordic (
      .clock      (clock),
      .enable     (adv),
      .x_in       (item_ff.a_re),
      .y_in       (item_ff.a_im),
      .cordic_out (cord)
   );

   cau_divider u_divider (
      .clock   (clock),
      .enable  (adv),
      .num_re  (sum_ff.div_re),
      .num_im  (sum_ff.div_im),
      .den     (sum_ff.den),
      .div_out (dv)
   );

   // result pipe, long commands merge in where their unit finishes
   always_comb begin
      pipe_in[S_EARLY].valid = v1_ff;
      pipe_in[S_EARLY].cmd   = item_ff.command;
      pipe_in[S_EARLY].res   = early_res;
      for (int k = S_EARLY + 1; k <= S_LAST; k++) begin
         pipe_in[k] = pipe_ff[k-1];
      end
      if (pipe_ff[S_MUL-1].cmd == cau_pkg::CMD_MUL) begin
         pipe_in[S_MUL].res = mul_res;
      end
      if (pipe_ff[S_CORD].cmd == cau_pkg::CMD_MAG) begin
         pipe_in[S_CORD+1].res     = '0;
         pipe_in[S_CORD+1].res.re  = cord.mag;
         pipe_in[S_CORD+1].res.ovf = cord.mag_ovf;
      end
      if (pipe_ff[S_CORD].cmd == cau_pkg::CMD_ANGLE) begin
         pipe_in[S_CORD+1].res    = '0;
         pipe_in[S_CORD+1].res.re = cord.angle;
      end
   end

   // output word
   always_comb begin
      cau_pkg::res_type r;
      r = pipe_ff[S_LAST].res;
      if (pipe_ff[S_LAST].cmd == cau_pkg::CMD_DIV) begin
         r      = '0;
         r.re   = dv.re;
         r.im   = dv.im;
         r.ovf  = dv.ovf;
         r.div0 = dv.div0;
      end
      rsp_in.res_re       = r.re;
      rsp_in.res_im       = r.im;
      rsp_in.compare_true = r.cmp;
      if (r.div0) begin
         rsp_in.status = cau_pkg::ST_DIV0;
      end else if (r.ovf) begin
         rsp_in.status = cau_pkg::ST_OVF;
      end else begin
         rsp_in.status = cau_pkg::ST_OK;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff       <= cau_pkg::TOL_RESET;
         v1_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            tol_ff <= csr_data;
         end
         if (adv) begin
            v1_ff        <= req_valid;
            rsp_valid_ff <= pipe_ff[S_LAST].valid;
         end
      end
   end

   // result pipe stages, only the valid bits are reset
   always_ff @(posedge clock) begin
      for (int k = S_EARLY; k <= S_LAST; k++) begin
         if (reset) begin
            pipe_ff[k].valid <= 1'b0;
         end else if (adv) begin
            pipe_ff[k].valid <= pipe_in[k].valid;
         end
         if (adv) begin
            pipe_ff[k].cmd <= pipe_in[k].cmd;
            pipe_ff[k].res <= pipe_in[k].res;
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (adv) begin
         item_ff     <= req_data;
         prod_ff     <= prod_in;
         sum_ff      <= sum_in;
         rsp_data_ff <= rsp_in;
      end
   end

   // a finished word in the last stage reaches the output register
   a_last_to_out: assert property (@(posedge clock) disable iff (reset)
      (adv && pipe_ff[S_LAST].valid) |=> rsp_valid_ff)
      else $error("word lost between last stage and output");

   // divide by zero gives zero parts
   a_div0_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status == cau_pkg::ST_DIV0)
      |-> (rsp_data_ff.res_re == 0 && rsp_data_ff.res_im == 0))
      else $error("divide by zero with nonzero result");

   // a compare result carries zero parts and ok status
   a_cmp_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.compare_true)
      |-> (rsp_data_ff.res_re == 0 && rsp_data_ff.res_im == 0
           && rsp_data_ff.status == cau_pkg::ST_OK))
      else $error("compare result with data or status");

   // status code always meaningful
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.status == cau_pkg::ST_OK
                        || rsp_data_ff.status == cau_pkg::ST_DIV0
                        || rsp_data_ff.status == cau_pkg::ST_OVF))
      else $error("undefined status code");

endmodule

// ===== sim/complex_arithmetic_unit_core_tb.sv =====
// testbench of the complex arithmetic unit: random and directed words checked against a predictor
`timescale 1ns / 1ps

module complex_arithmetic_unit_core_tb;

   localparam int PIPE_LAT   = 40;
   localparam int IDLE_LIMIT = 4000;

   // expected results, oldest first, and the mismatch count
   class cau_scoreboard;
      cau_pkg::rsp_type pending[$];
      int               errors = 0;

      function void note_word(input cau_pkg::rsp_type r);
         pending.push_back(r);
      endfunction

      task report(input string what, input longint got, input longint want);
         $display("mismatch %s: got %0d expected %0d", what, got, want);
         errors++;
      endtask

      task check_word(input cau_pkg::rsp_type r);
         cau_pkg::rsp_type e;
         if (pending.size() == 0) begin
            $display("mismatch: result word with nothing expected");
            errors++;
         end else begin
            e = pending.pop_front();
            if (r.res_re !== e.res_re) report("res_re", r.res_re, e.res_re);
            if (r.res_im !== e.res_im) report("res_im", r.res_im, e.res_im);
            if (r.compare_true !== e.compare_true)
               report("compare_true", r.compare_true, e.compare_true);
            if (r.status !== e.status) report("status", r.status, e.status);
         end
      endtask
   endclass

   logic                      clock = 0;
   logic                      reset = 1;
   logic                      req_valid = 0;
   logic                      req_stall;
   cau_pkg::req_type          req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 0;
   cau_pkg::rsp_type          rsp_data;
   logic                      csr_valid = 0;
   logic                      csr_ready;
   logic [cau_pkg::TOL_W-1:0] csr_data = '0;

   cau_scoreboard             board = new();
   logic [cau_pkg::TOL_W-1:0] tolerance = cau_pkg::TOL_RESET;
   bit                        quiet_mode = 0;   // no idling on either side
   bit                        hold_rsp = 0;     // long receiver hold-off
   int                        idle_cycles = 0;
   bit                        stim_done = 0;

   complex_arithmetic_unit_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial forever #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic longint shr_arith(input longint v, input int n);
      return v >>> n;
   endfunction

   // clamp a sign-magnitude value into the 32 bit range
   function automatic logic signed [31:0] clamp_sm(input bit neg, input logic [63:0] mag,
                                                   inout bit ovf);
      if (neg) begin
         if (mag > 64'h8000_0000) begin
            ovf = 1;
            return 32'sh8000_0000;
         end
         return 32'(64'd0 - mag);
      end
      if (mag > 64'h7FFF_FFFF) begin
         ovf = 1;
         return 32'sh7FFF_FFFF;
      end
      return 32'(mag);
   endfunction

   function automatic logic signed [31:0] clamp_val(input longint v, inout bit ovf);
      if (v < 0) return clamp_sm(1, 64'd0 - 64'(v), ovf);
      return clamp_sm(0, 64'(v), ovf);
   endfunction

   // 64 bit wrapped sum to sign and magnitude; the most negative value reads as positive
   function automatic bit to_sm(input logic [63:0] u, output logic [63:0] mag);
      bit neg;
      neg = u[63] && (u != 64'h8000_0000_0000_0000);
      mag = neg ? 64'd0 - u : u;
      return neg;
   endfunction

   // fixed-point quotient with early saturation, truncated toward zero
   function automatic logic signed [31:0] fx_quotient(input bit neg, input logic [63:0] num,
                                                      input logic [63:0] den, inout bit ovf);
      logic [63:0] lim, q, r;
      lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      q = num / den;
      r = num % den;
      if (q > lim) return clamp_sm(neg, lim + 1, ovf);
      for (int i = 0; i < cau_pkg::FRAC_W; i++) begin
         if (q > (lim >> 1)) return clamp_sm(neg, lim + 1, ovf);
         r = r << 1;
         q = q << 1;
         if (r >= den) begin
            r = r - den;
            q[0] = 1'b1;
         end
         if (q > lim) return clamp_sm(neg, lim + 1, ovf);
      end
      return clamp_sm(neg, q, ovf);
   endfunction

   // vectoring cordic: x gain-scaled magnitude, z angle in q16.16 degrees
   function automatic void vector_rotate(input longint xi, input longint yi,
                                         output longint xo, output longint zo);
      longint x, y, z, dx, dy;
      x = xi; y = yi; z = 0;
      if (x < 0) begin
         z = (y >= 0) ? 64'(cau_pkg::DEG180) : -64'(cau_pkg::DEG180);
         x = -x;
         y = -y;
      end
      for (int i = 0; i < cau_pkg::CORDIC_STEPS; i++) begin
         dx = shr_arith(y, i);
         dy = shr_arith(x, i);
         if (y > 0) begin
            x += dx; y -= dy; z += cau_pkg::atan_deg(i);
         end else begin
            x -= dx; y += dy; z -= cau_pkg::atan_deg(i);
         end
      end
      if (z > 64'(cau_pkg::DEG180)) z = cau_pkg::DEG180;
      if (z < -64'(cau_pkg::DEG180)) z = -64'(cau_pkg::DEG180);
      xo = x;
      zo = z;
   endfunction

   function automatic cau_pkg::rsp_type predict_result(input cau_pkg::req_type w,
                                                       input logic [cau_pkg::TOL_W-1:0] tol);
      cau_pkg::rsp_type r;
      longint           ar, ai, br, bi, x, z, dr, di;
      logic [63:0]      mag, den;
      bit               ovf, neg;
      r = '0;
      ovf = 0;
      ar = w.a_re; ai = w.a_im; br = w.b_re; bi = w.b_im;
      case (w.command)
         cau_pkg::CMD_ADD: begin
            r.res_re = clamp_val(ar + br, ovf);
            r.res_im = clamp_val(ai + bi, ovf);
         end
         cau_pkg::CMD_SUB: begin
            r.res_re = clamp_val(ar - br, ovf);
            r.res_im = clamp_val(ai - bi, ovf);
         end
         cau_pkg::CMD_MUL: begin
            neg = to_sm(64'(ar * br) - 64'(ai * bi), mag);
            r.res_re = clamp_sm(neg, mag >> cau_pkg::FRAC_W, ovf);
            neg = to_sm(64'(ai * br) + 64'(ar * bi), mag);
            r.res_im = clamp_sm(neg, mag >> cau_pkg::FRAC_W, ovf);
         end
         cau_pkg::CMD_DIV: begin
            den = 64'(br * br) + 64'(bi * bi);
            if (den == 0) begin
               r.status = cau_pkg::ST_DIV0;
            end else begin
               neg = to_sm(64'(ar * br) + 64'(ai * bi), mag);
               r.res_re = fx_quotient(neg, mag, den, ovf);
               neg = to_sm(64'(ai * br) - 64'(ar * bi), mag);
               r.res_im = fx_quotient(neg, mag, den, ovf);
            end
         end
         cau_pkg::CMD_CONJ: begin
            r.res_re = clamp_val(ar, ovf);
            r.res_im = clamp_val(-ai, ovf);
         end
         cau_pkg::CMD_EQ, cau_pkg::CMD_NE: begin
            dr = ar - br; di = ai - bi;
            if (dr < 0) dr = -dr;
            if (di < 0) di = -di;
            r.compare_true = ((dr < longint'(tol)) && (di < longint'(tol)))
                             ^ (w.command == cau_pkg::CMD_NE);
         end
         cau_pkg::CMD_MAG: begin
            vector_rotate(ar, ai, x, z);
            r.res_re = clamp_sm(0, (64'(x) * 64'(cau_pkg::INV_GAIN)) >> 30, ovf);
         end
         cau_pkg::CMD_ANGLE: begin
            vector_rotate(ar, ai, x, z);
            if (ar == 0 && ai == 0) z = 0;
            r.res_re = clamp_val(z, ovf);
         end
         default: ;
      endcase
      if (ovf && r.status == cau_pkg::ST_OK) r.status = cau_pkg::ST_OVF;
      return r;
   endfunction

   // ---------------------------------------------------------------- drivers

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'(int'($urandom_range(0, 20)) - 10);
         3: return 32'(int'($urandom_range(0, 32'h40000)) - 32'h20000);
         4: return '0;
         5: return 32'(int'($urandom_range(0, 32'h2000000)) - 32'h1000000);
         default: return $urandom();
      endcase
   endfunction

   // offer one word and hold it until the block takes it
   task send_word(input cau_pkg::req_type w);
      if (!quiet_mode)
         while ($urandom_range(0, 99) < 38) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_word(predict_result(w, tolerance));
   endtask

   task send_random(input int n, input bit near);
      cau_pkg::req_type w;
      repeat (n) begin
         w.command = 4'($urandom_range(0, 15));
         if ($urandom_range(0, 9) < 8) w.command = 4'($urandom_range(0, 8));
         w.a_re = pick_value(); w.a_im = pick_value();
         if (near || $urandom_range(0, 3) == 0) begin
            // small offsets so equality goes both ways
            w.b_re = w.a_re + 32'(int'($urandom_range(0, 40)) - 20);
            w.b_im = w.a_im + 32'(int'($urandom_range(0, 40)) - 20);
         end else begin
            w.b_re = pick_value(); w.b_im = pick_value();
         end
         send_word(w);
      end
      req_valid <= 1'b0;
   endtask

   // wait for the pipe to drain, then write the tolerance register
   task write_tolerance(input logic [cau_pkg::TOL_W-1:0] v);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (PIPE_LAT) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      tolerance = v;
   endtask

   task send_directed();
      logic [31:0] edges[5] = '{32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h0001_0000, 32'hFFFF_FFFF};
      cau_pkg::req_type w;
      for (int c = 0; c <= 9; c++) begin
         w.command = (c == 9) ? 4'hF : 4'(c);
         w.a_re = edges[c % 5]; w.a_im = edges[(c + 1) % 5];
         w.b_re = edges[(c + 2) % 5]; w.b_im = edges[(c + 3) % 5];
         send_word(w);
      end
      // divide by zero, conjugate of the most negative imaginary part
      send_word('{cau_pkg::CMD_DIV, 32'h0001_0000, 32'h5, 32'h0, 32'h0});
      send_word('{cau_pkg::CMD_CONJ, 32'h5, 32'h8000_0000, 32'h0, 32'h0});
      // angle of zero, negative real axis, magnitude of the extremes
      send_word('{cau_pkg::CMD_ANGLE, 32'h0, 32'h0, 32'h0, 32'h0});
      send_word('{cau_pkg::CMD_ANGLE, 32'hFFFF_0000, 32'h0, 32'h0, 32'h0});
      send_word('{cau_pkg::CMD_MAG, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0});
      send_word('{cau_pkg::CMD_MAG, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0});
      // tolerance edges: difference 6 and 7 at the reset value
      send_word('{cau_pkg::CMD_EQ, 32'h10, 32'h10, 32'h16, 32'h10});
      send_word('{cau_pkg::CMD_EQ, 32'h10, 32'h10, 32'h17, 32'h10});
      send_word('{cau_pkg::CMD_NE, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0});
      send_word('{cau_pkg::CMD_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000});
      send_word('{cau_pkg::CMD_DIV, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h1});
      req_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------- receiver

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_rsp) begin
         rsp_stall <= 1'b1;
      end else if (quiet_mode) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 38);
      end
   end

   // result checking and idle watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) board.check_word(rsp_data);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)
             || (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("complex_arithmetic_unit_core_tb NOT OK");
            $finish;
         end
      end
   end

   // long receiver hold-off while the sender keeps offering words
   initial begin
      while (stim_done || board.pending.size() <= 20) @(posedge clock);
      hold_rsp = 1;
      repeat (300) @(posedge clock);
      hold_rsp = 0;
   end

   // ---------------------------------------------------------------- main flow

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_directed();
      write_tolerance(16'd0);
      send_random(60, 1);
      write_tolerance(16'hFFFF);
      send_random(60, 1);
      write_tolerance(16'd12);
      quiet_mode = 1;
      send_random(200, 0);
      quiet_mode = 0;
      send_random(300, 0);
      write_tolerance(16'd1);
      send_random(110, 1);
      stim_done = 1;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (PIPE_LAT) @(posedge clock);
      if (board.errors == 0)
         $display("complex_arithmetic_unit_core_tb OK");
      else
         $display("complex_arithmetic_unit_core_tb NOT OK");
      $finish;
   end

endmodule
